### design/mrrb_pkg.sv
// Shared constants, codes and control types of the multi-reader ring buffer.
package mrrb_pkg;

    localparam int DEPTH       = 512;
    localparam int NUM_READERS = 4;
    localparam int NUM_TARGETS = 4;

    localparam int PTR_W     = $clog2(DEPTH);
    localparam int VALUE_W   = 48;
    localparam int COUNT_W   = 32;
    localparam int RDR_W     = 2;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 3;
    localparam int ACTIVE_W  = 3;
    localparam int CFG_IDX_W = 3;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 88;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(4);
    localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_END   = 2'd2,
        OP_END_X = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_WRITTEN  = 3'd0,
        STS_FULL     = 3'd1,
        STS_READ_OK  = 3'd2,
        STS_EMPTY    = 3'd3,
        STS_FINISHED = 3'd4,
        STS_END_ACK  = 3'd5
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_READERS = 3'd0,
        CFG_TARGET_0       = 3'd1,
        CFG_TARGET_1       = 3'd2,
        CFG_TARGET_2       = 3'd3,
        CFG_TARGET_3       = 3'd4
    } cfg_idx_t;

    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_EXEC = 1'b1
    } fsm_t;

    typedef struct packed {
        logic load;    // take the input word, start the ring read
        logic commit;  // update state and load the result register
    } mrrb_cmd_t;

    typedef struct packed {
        logic out_free;  // result register empty or being drained
    } mrrb_sts_t;

endpackage

### design/mrrb_ram.sv
// Generic single-port-write, registered-read RAM.
module mrrb_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### design/mrrb_ctrl.sv
// Controller state machine: accept, then commit once the result register is free.
module mrrb_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  mrrb_pkg::mrrb_sts_t sts,
    output mrrb_pkg::mrrb_cmd_t cmd
);
    import mrrb_pkg::*;

    fsm_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE: begin
                if (s_tvalid) begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC: begin
                if (sts.out_free) begin
                    state_next = FSM_IDLE;
                end
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            FSM_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            FSM_EXEC: begin
                cmd.commit = sts.out_free;
            end
            default: ;
        endcase
    end

endmodule

### design/mrrb_dp.sv
// Datapath: config registers, pointers, counts, ring RAM and result register.
module mrrb_dp (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  mrrb_pkg::mrrb_cmd_t              cmd,
    output mrrb_pkg::mrrb_sts_t              sts,
    input  logic [mrrb_pkg::OP_W-1:0]        in_op,
    input  logic [mrrb_pkg::VALUE_W-1:0]     in_value,
    input  logic [mrrb_pkg::RDR_W-1:0]       in_reader,
    input  logic                             cfg_we,
    input  logic [mrrb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mrrb_pkg::VALUE_W-1:0]     cfg_wdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mrrb_pkg::STATUS_W-1:0]    m_status,
    output logic [mrrb_pkg::VALUE_W-1:0]     m_read_value,
    output logic                             m_matched,
    output logic [mrrb_pkg::COUNT_W-1:0]     m_match_count
);
    import mrrb_pkg::*;

    // configuration
    logic [ACTIVE_W-1:0] active_reg;
    logic [VALUE_W-1:0]  target_reg [NUM_TARGETS];

    // ring state
    logic [PTR_W-1:0]   wp_reg, wp_next;
    logic [PTR_W-1:0]   rp_reg [NUM_READERS];
    logic [COUNT_W-1:0] cnt_reg [NUM_READERS];
    logic               ended_reg;

    // latched input word
    logic [OP_W-1:0]    op_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [RDR_W-1:0]   rdr_reg;

    // result register
    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic [VALUE_W-1:0]  m_value_reg, m_value_next;
    logic                m_matched_reg, m_matched_next;
    logic [COUNT_W-1:0]  m_count_reg, m_count_next;

    logic [ACTIVE_W-1:0] eff_readers;
    logic [PTR_W-1:0]    raddr;
    logic [PTR_W-1:0]    rp_sel, rp_adv;
    logic [COUNT_W-1:0]  cnt_sel, cnt_upd;
    logic [VALUE_W-1:0]  tgt_sel;
    logic [VALUE_W-1:0]  ram_rdata;
    logic                full, rd_active, rd_empty, hit;
    logic                do_write, do_read;

    assign sts.out_free = !m_valid_reg || m_tready;

    // effective reader count: 0 acts as 1, above NUM_READERS clips
    always_comb begin
        if (active_reg == '0) begin
            eff_readers = ACTIVE_W'(1);
        end else if (active_reg > ACTIVE_W'(NUM_READERS)) begin
            eff_readers = ACTIVE_W'(NUM_READERS);
        end else begin
            eff_readers = active_reg;
        end
    end

    // read address for the ring, taken from the incoming reader index
    always_comb begin
        raddr = '0;
        for (int j = 0; j < NUM_READERS; j++) begin
            if (in_reader == RDR_W'(j)) begin
                raddr = rp_reg[j];
            end
        end
    end

    always_comb begin
        rp_sel  = '0;
        cnt_sel = '0;
        tgt_sel = '0;
        for (int j = 0; j < NUM_READERS; j++) begin
            if (rdr_reg == RDR_W'(j)) begin
                rp_sel  = rp_reg[j];
                cnt_sel = cnt_reg[j];
                tgt_sel = target_reg[j];
            end
        end
    end

    assign wp_next = (wp_reg == PTR_W'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign rp_adv  = (rp_sel == PTR_W'(DEPTH - 1)) ? '0 : rp_sel + 1'b1;

    // full when the slot after the write pointer is held by any active reader
    always_comb begin
        full = 1'b0;
        for (int j = 0; j < NUM_READERS; j++) begin
            if (ACTIVE_W'(j) < eff_readers && rp_reg[j] == wp_next) begin
                full = 1'b1;
            end
        end
    end

    assign rd_active = ACTIVE_W'(rdr_reg) < eff_readers;
    assign rd_empty  = rp_sel == wp_reg;
    assign hit       = ram_rdata == tgt_sel;
    assign cnt_upd   = (hit && cnt_sel != COUNT_MAX) ? cnt_sel + 1'b1 : cnt_sel;
    assign do_write  = cmd.commit && op_reg == OP_WRITE && !full;
    assign do_read   = cmd.commit && op_reg == OP_READ && rd_active && !rd_empty;

    always_comb begin
        m_status_next  = STS_END_ACK;
        m_value_next   = '0;
        m_matched_next = 1'b0;
        m_count_next   = '0;
        case (op_reg)
            OP_WRITE: begin
                m_status_next = full ? STS_FULL : STS_WRITTEN;
            end
            OP_READ: begin
                if (rd_active && !rd_empty) begin
                    m_status_next  = STS_READ_OK;
                    m_value_next   = ram_rdata;
                    m_matched_next = hit;
                    m_count_next   = cnt_upd;
                end else begin
                    m_status_next = ended_reg ? STS_FINISHED : STS_EMPTY;
                    m_count_next  = cnt_sel;
                end
            end
            default: m_status_next = STS_END_ACK;
        endcase
    end

    mrrb_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (do_write),
        .waddr (wp_reg),
        .wdata (value_reg),
        .re    (cmd.load),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= ACTIVE_RESET;
            for (int j = 0; j < NUM_TARGETS; j++) begin
                target_reg[j] <= '0;
            end
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ACTIVE_READERS: active_reg    <= cfg_wdata[ACTIVE_W-1:0];
                CFG_TARGET_0:       target_reg[0] <= cfg_wdata;
                CFG_TARGET_1:       target_reg[1] <= cfg_wdata;
                CFG_TARGET_2:       target_reg[2] <= cfg_wdata;
                CFG_TARGET_3:       target_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= in_op;
            value_reg <= in_value;
            rdr_reg   <= in_reader;
        end
        if (cmd.commit) begin
            m_status_reg  <= m_status_next;
            m_value_reg   <= m_value_next;
            m_matched_reg <= m_matched_next;
            m_count_reg   <= m_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg      <= '0;
            ended_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int j = 0; j < NUM_READERS; j++) begin
                rp_reg[j]  <= '0;
                cnt_reg[j] <= '0;
            end
        end else begin
            if (do_write) begin
                wp_reg <= wp_next;
            end
            if (cmd.commit && op_reg[1]) begin
                ended_reg <= 1'b1;
            end
            if (do_read) begin
                for (int j = 0; j < NUM_READERS; j++) begin
                    if (rdr_reg == RDR_W'(j)) begin
                        rp_reg[j]  <= rp_adv;
                        cnt_reg[j] <= cnt_upd;
                    end
                end
            end
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid      = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_read_value  = m_value_reg;
    assign m_matched     = m_matched_reg;
    assign m_match_count = m_count_reg;

    a_write_moves_wp: assert property (@(posedge aclk) disable iff (!aresetn)
        do_write |=> wp_reg != $past(wp_reg))
        else $error("accepted write did not advance the write pointer");

    a_no_commit_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> !m_valid_reg || m_tready)
        else $error("result register overwritten before it was taken");

    a_value_only_on_read: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_status_reg != STS_READ_OK |-> m_value_reg == '0 && !m_matched_reg)
        else $error("read value or match flag set on a non-read result");

    a_end_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit && op_reg[1] |=> ended_reg)
        else $error("end of input not recorded");

endmodule

### design/multi_reader_ring_buffer_match_count_unit.sv
// Top level of the multi-reader ring buffer with per-reader match counting.
// A word accepted in IDLE fires the ring RAM's registered read; its result is loaded into the
// result register when EXEC commits. A new word is taken only after that commit, so words do
// not overlap; a result held by m_tready stalls the next commit, s_tready stays low.
// Reset (aresetn, synchronous, active low) clears pointers, counts, the end flag, targets,
// sets active_readers to 4; the ring RAM itself is not cleared and needs no clearing pass.
module multi_reader_ring_buffer_match_count_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [mrrb_pkg::S_TDATA_W-1:0]     s_tdata,   // value[47:0], reader[49:48], zero pad
    input  logic [mrrb_pkg::OP_W-1:0]          s_tuser,   // op[1:0]
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [mrrb_pkg::M_TDATA_W-1:0]     m_tdata,   // read_value[47:0], matched[48],
                                                          // match_count[80:49], zero pad
    output logic [mrrb_pkg::STATUS_W-1:0]      m_tuser,   // status[2:0]
    // configuration write port
    input  logic                               cfg_we,
    input  logic [mrrb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mrrb_pkg::VALUE_W-1:0]       cfg_wdata
);
    import mrrb_pkg::*;

    mrrb_cmd_t cmd;
    mrrb_sts_t sts;

    logic [VALUE_W-1:0] m_read_value;
    logic               m_matched;
    logic [COUNT_W-1:0] m_match_count;

    // Controller: IDLE takes a word (and fires the ring read), EXEC commits it
    // as soon as the result register is empty or being drained.
    mrrb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: ring RAM, write/read pointers, full check over the active
    // readers, saturating match counters and the output word register.
    mrrb_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .in_op         (s_tuser),
        .in_value      (s_tdata[VALUE_W-1:0]),
        .in_reader     (s_tdata[VALUE_W +: RDR_W]),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_status      (m_tuser),
        .m_read_value  (m_read_value),
        .m_matched     (m_matched),
        .m_match_count (m_match_count)
    );

    // pack result word, lowest field first
    assign m_tdata = {{(M_TDATA_W - VALUE_W - 1 - COUNT_W){1'b0}},
                      m_match_count, m_matched, m_read_value};

endmodule
